// File: sv/assert_macros.svh
// Assertion helpers used by the decoder RTL. Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define NECIR_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("necir: invariant violated");

// A condition that, once seen, must be followed by another in the next cycle.
`define NECIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("necir: sequence violated");

`endif

// File: sv/necir_pkg.sv
package necir_pkg;

  localparam int CNT_W          = 8;
  localparam int DURATION_SLOTS = 128;
  localparam int DATA_DURATIONS = 66;
  localparam int REPEAT_MAX     = 9;
  localparam int NUM_REGS       = 7;
  localparam int REG_W          = 16;
  localparam int IDX_W          = 3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_GAP_THRESHOLD = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_PULSE   = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_SPACE   = 3'd2;
  localparam logic [IDX_W-1:0] REG_BIT_PULSE     = 3'd3;
  localparam logic [IDX_W-1:0] REG_ONE_SPACE     = 3'd4;
  localparam logic [IDX_W-1:0] REG_ZERO_SPACE    = 3'd5;
  localparam logic [IDX_W-1:0] REG_TOLERANCE     = 3'd6;

  localparam logic [REG_W-1:0] RST_GAP_THRESHOLD = 16'd15000;
  localparam logic [REG_W-1:0] RST_START_PULSE   = 16'd9000;
  localparam logic [REG_W-1:0] RST_START_SPACE   = 16'd4500;
  localparam logic [REG_W-1:0] RST_BIT_PULSE     = 16'd560;
  localparam logic [REG_W-1:0] RST_ONE_SPACE     = 16'd1690;
  localparam logic [REG_W-1:0] RST_ZERO_SPACE    = 16'd560;
  localparam logic [REG_W-1:0] RST_TOLERANCE     = 16'd200;

  // Event codes on the func field.
  localparam logic FUNC_EDGE    = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_REPEAT  = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic        func;
    logic [31:0] stamp_us;
  } in_item_t;

  typedef struct packed {
    frame_kind_t frame_kind;
    logic [7:0]  address;
    logic [7:0]  command;
  } out_item_t;

endpackage

// File: sv/necir_match.sv
module necir_match (
  input  logic [31:0]               dur,
  input  logic [necir_pkg::REG_W-1:0] nom,
  input  logic [necir_pkg::REG_W-1:0] tol,
  output logic                      hit
);
  import necir_pkg::*;

  logic [REG_W-1:0] lo;
  logic [REG_W:0]   hi;

  // The lower bound saturates at zero; the upper bound gets one extra bit.
  assign lo  = (nom > tol) ? (nom - tol) : '0;
  assign hi  = {1'b0, nom} + {1'b0, tol};
  assign hit = (dur >= {{(32-REG_W){1'b0}}, lo}) && (dur <= {{(31-REG_W){1'b0}}, hi});

endmodule

// File: sv/nec_ir_frame_decoder_unit.sv
// NEC infrared frame decoder. Each request carries an edge timestamp or a timeout
// event; one request is taken per clock cycle, and the request that ends a frame
// passes an input register, then one decode pass that updates the frame state and
// loads the output register with the result. Throughput is one request per cycle
// and drops only while a waiting result is stalled on the output side.
// Configuration is written through a plain indexed write port; the user must
// write it only while the block is idle; the block does not enforce this.
`include "assert_macros.svh"

module nec_ir_frame_decoder_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  necir_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output necir_pkg::out_item_t              out_data,
  input  logic                              cfg_we,
  input  logic [necir_pkg::IDX_W-1:0]       cfg_index,
  input  logic [necir_pkg::REG_W-1:0]       cfg_wdata
);
  import necir_pkg::*;

  // Configuration registers.
  logic [REG_W-1:0] gap_r, start_pulse_r, start_space_r, bit_pulse_r;
  logic [REG_W-1:0] one_space_r, zero_space_r, tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r         <= RST_GAP_THRESHOLD;
      start_pulse_r <= RST_START_PULSE;
      start_space_r <= RST_START_SPACE;
      bit_pulse_r   <= RST_BIT_PULSE;
      one_space_r   <= RST_ONE_SPACE;
      zero_space_r  <= RST_ZERO_SPACE;
      tol_r         <= RST_TOLERANCE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAP_THRESHOLD: gap_r         <= cfg_wdata;
        REG_START_PULSE:   start_pulse_r <= cfg_wdata;
        REG_START_SPACE:   start_space_r <= cfg_wdata;
        REG_BIT_PULSE:     bit_pulse_r   <= cfg_wdata;
        REG_ONE_SPACE:     one_space_r   <= cfg_wdata;
        REG_ZERO_SPACE:    zero_space_r  <= cfg_wdata;
        REG_TOLERANCE:     tol_r         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register and pipeline control.
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     out_valid_r;
  out_item_t out_item_r;
  logic     advance;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  // Frame state.
  logic [31:0]      last_stamp_r, last_stamp_nxt;
  logic             have_last_r, have_last_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      shift_r, shift_nxt;
  logic             bad_r, bad_nxt;

  logic [31:0]      dur;
  logic [REG_W-1:0] mark_nom;
  logic             mark_hit, one_hit, zero_hit;

  assign dur = s1_item_r.stamp_us - last_stamp_r;

  always_comb begin
    if (count_r == CNT_W'(0)) begin
      mark_nom = start_pulse_r;
    end else if (count_r == CNT_W'(1)) begin
      mark_nom = start_space_r;
    end else begin
      mark_nom = bit_pulse_r;
    end
  end

  necir_match u_match_mark (.dur(dur), .nom(mark_nom),     .tol(tol_r), .hit(mark_hit));
  necir_match u_match_one  (.dur(dur), .nom(one_space_r),  .tol(tol_r), .hit(one_hit));
  necir_match u_match_zero (.dur(dur), .nom(zero_space_r), .tol(tol_r), .hit(zero_hit));

  // Frame classification from the state held before this request.
  out_item_t finish;
  always_comb begin
    finish.frame_kind = KIND_INVALID;
    finish.address    = '0;
    finish.command    = '0;
    if (count_r >= CNT_W'(DATA_DURATIONS)) begin
      if (!bad_r && ((shift_r[31:24] ^ shift_r[23:16]) == 8'hFF)
          && ((shift_r[15:8] ^ shift_r[7:0]) == 8'hFF)) begin
        finish.frame_kind = KIND_DATA;
        finish.address    = shift_r[31:24];
        finish.command    = shift_r[15:8];
      end
    end else if (count_r != CNT_W'(0) && count_r <= CNT_W'(REPEAT_MAX)) begin
      finish.frame_kind = KIND_REPEAT;
    end
  end

  logic do_step;
  logic emit;
  assign do_step = s1_valid_r && advance;

  always_comb begin
    last_stamp_nxt = last_stamp_r;
    have_last_nxt  = have_last_r;
    count_nxt      = count_r;
    shift_nxt      = shift_r;
    bad_nxt        = bad_r;
    emit           = 1'b0;
    if (do_step) begin
      if (s1_item_r.func == FUNC_TIMEOUT) begin
        emit          = 1'b1;
        count_nxt     = '0;
        shift_nxt     = '0;
        bad_nxt       = 1'b0;
        have_last_nxt = 1'b0;
      end else if (!have_last_r) begin
        have_last_nxt  = 1'b1;
        last_stamp_nxt = s1_item_r.stamp_us;
      end else begin
        last_stamp_nxt = s1_item_r.stamp_us;
        if (dur > {16'b0, gap_r}) begin
          emit      = (count_r != CNT_W'(0));
          count_nxt = '0;
          shift_nxt = '0;
          bad_nxt   = 1'b0;
        end else if (count_r < CNT_W'(DURATION_SLOTS)) begin
          count_nxt = count_r + CNT_W'(1);
          if (count_r < CNT_W'(2)) begin
            bad_nxt = bad_r | !mark_hit;
          end else if (count_r < CNT_W'(DATA_DURATIONS)) begin
            if (!count_r[0]) begin
              bad_nxt = bad_r | !mark_hit;
            end else if (one_hit) begin
              // A space that fits both nominals is taken as a one.
              shift_nxt = {shift_r[30:0], 1'b1};
            end else begin
              shift_nxt = {shift_r[30:0], 1'b0};
              bad_nxt   = bad_r | !zero_hit;
            end
          end
        end else begin
          // Too many durations: the frame is dropped without a result.
          count_nxt     = '0;
          shift_nxt     = '0;
          bad_nxt       = 1'b0;
          have_last_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r <= '0;
      have_last_r  <= 1'b0;
      count_r      <= '0;
      shift_r      <= '0;
      bad_r        <= 1'b0;
    end else begin
      last_stamp_r <= last_stamp_nxt;
      have_last_r  <= have_last_nxt;
      count_r      <= count_nxt;
      shift_r      <= shift_nxt;
      bad_r        <= bad_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_item_r <= finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  `NECIR_ASSERT(a_count_bound, count_r <= CNT_W'(DURATION_SLOTS))
  `NECIR_ASSERT(a_count_needs_ref, (count_r == CNT_W'(0)) || have_last_r)
  `NECIR_ASSERT(a_plain_fields_zero, !out_valid_r || (out_item_r.frame_kind == KIND_DATA) ||
    ((out_item_r.address == 8'h00) && (out_item_r.command == 8'h00)))
  `NECIR_ASSERT_NEXT(a_timeout_reports, do_step && (s1_item_r.func == FUNC_TIMEOUT), out_valid_r)

endmodule

// File: tb/sv/nec_ir_frame_decoder_unit_tb.sv
`timescale 1ns / 1ps

module nec_ir_frame_decoder_unit_tb;
  import necir_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 230;

  typedef enum int {
    FLAW_NONE,
    FLAW_ADDR_SUM,
    FLAW_CMD_SUM,
    FLAW_BAD_DUR,
    FLAW_SHORT,
    FLAW_LONG,
    FLAW_TAIL
  } flaw_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wdata = '0;

  nec_ir_frame_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Timing registers as last written, and the decoder state they act on.
  logic [REG_W-1:0] cfg_shadow [NUM_REGS];
  logic [31:0] ref_stamp = '0;
  logic ref_valid = 1'b0;
  logic [CNT_W-1:0] dur_count = '0;
  logic [31:0] bit_word = '0;
  logic frame_bad = 1'b0;

  in_item_t edge_events[$];
  out_item_t expected_frames[$];
  int queued_cnt = 0;
  int accepted_cnt = 0;
  int fails = 0;

  // Stimulus-side view of the pin: last stamp issued and whether it is a reference.
  logic [31:0] gen_stamp = '0;
  logic gen_have_ref = 1'b0;

  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  logic [9:0] stall_phase = '0;
  int cycle_cnt = 0;

  function automatic logic in_window(logic [31:0] d, logic [REG_W-1:0] nom);
    logic [31:0] tol, lo, hi;
    tol = {16'd0, cfg_shadow[REG_TOLERANCE]};
    lo = ({16'd0, nom} > tol) ? {16'd0, nom} - tol : 32'd0;
    hi = {16'd0, nom} + tol;
    return (d >= lo) && (d <= hi);
  endfunction

  function automatic void clear_frame();
    dur_count = '0;
    bit_word = '0;
    frame_bad = 1'b0;
  endfunction

  function automatic void absorb_duration(logic [31:0] d);
    if (dur_count == 0) begin
      if (!in_window(d, cfg_shadow[REG_START_PULSE])) frame_bad = 1'b1;
    end else if (dur_count == 1) begin
      if (!in_window(d, cfg_shadow[REG_START_SPACE])) frame_bad = 1'b1;
    end else if (dur_count < DATA_DURATIONS) begin
      if (!dur_count[0]) begin
        if (!in_window(d, cfg_shadow[REG_BIT_PULSE])) frame_bad = 1'b1;
      end else if (in_window(d, cfg_shadow[REG_ONE_SPACE])) begin
        // A space inside both windows decodes as a one.
        bit_word = {bit_word[30:0], 1'b1};
      end else if (in_window(d, cfg_shadow[REG_ZERO_SPACE])) begin
        bit_word = {bit_word[30:0], 1'b0};
      end else begin
        bit_word = {bit_word[30:0], 1'b0};
        frame_bad = 1'b1;
      end
    end
    dur_count = dur_count + 1'b1;
  endfunction

  function automatic out_item_t close_frame();
    out_item_t r;
    r = '0;
    r.frame_kind = KIND_INVALID;
    if (dur_count >= DATA_DURATIONS) begin
      if (!frame_bad && (bit_word[31:24] ^ bit_word[23:16]) == 8'hFF &&
          (bit_word[15:8] ^ bit_word[7:0]) == 8'hFF) begin
        r.frame_kind = KIND_DATA;
        r.address = bit_word[31:24];
        r.command = bit_word[15:8];
      end
    end else if (dur_count >= 1 && dur_count <= REPEAT_MAX) begin
      r.frame_kind = KIND_REPEAT;
    end
    return r;
  endfunction

  function automatic void decode_edge_event(in_item_t ev);
    logic [31:0] d;
    if (ev.func == FUNC_TIMEOUT) begin
      expected_frames.push_back(close_frame());
      clear_frame();
      ref_valid = 1'b0;
    end else if (!ref_valid) begin
      ref_valid = 1'b1;
      ref_stamp = ev.stamp_us;
    end else begin
      d = ev.stamp_us - ref_stamp;
      ref_stamp = ev.stamp_us;
      if (d > {16'd0, cfg_shadow[REG_GAP_THRESHOLD]}) begin
        if (dur_count != 0) expected_frames.push_back(close_frame());
        clear_frame();
      end else if (dur_count < DURATION_SLOTS) begin
        absorb_duration(d);
      end else begin
        // Too many durations: the frame is dropped without a result.
        clear_frame();
        ref_valid = 1'b0;
      end
    end
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_edge_event(in_data);
        accepted_cnt++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (edge_events.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= edge_events.pop_front();
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(1, 3);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall pattern, with one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      stall_phase <= '0;
    end else begin
      stall_phase <= stall_phase + 1'b1;
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (stall_phase[9:8])
          2'd0: out_stall <= 1'b0;
          2'd1: out_stall <= ($urandom_range(0, 3) == 0);
          2'd2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (stall_phase[2:0] < 3'd3);
        endcase
      end
    end
  end

  task automatic report_bad(string what, out_item_t want, out_item_t got);
    fails++;
    if (fails <= 10) begin
      $display("%s: expected kind %0d addr %02h cmd %02h, got kind %0d addr %02h cmd %02h",
               what, want.frame_kind, want.address, want.command,
               got.frame_kind, got.address, got.command);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        report_bad("frame result with none pending", '0, out_data);
      end else begin
        want = expected_frames.pop_front();
        if (out_data.frame_kind !== want.frame_kind || out_data.address !== want.address ||
            out_data.command !== want.command) begin
          report_bad("frame result mismatch", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_shadow[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_timing(logic [REG_W-1:0] gap, lead_mark, lead_space, mark,
                                logic [REG_W-1:0] one_sp, zero_sp, tol);
    write_reg(REG_GAP_THRESHOLD, gap);
    write_reg(REG_START_PULSE, lead_mark);
    write_reg(REG_START_SPACE, lead_space);
    write_reg(REG_BIT_PULSE, mark);
    write_reg(REG_ONE_SPACE, one_sp);
    write_reg(REG_ZERO_SPACE, zero_sp);
    write_reg(REG_TOLERANCE, tol);
  endtask

  task automatic program_random_timing();
    program_timing(REG_W'($urandom_range(12000, 65535)), REG_W'($urandom_range(2000, 12000)),
                   REG_W'($urandom_range(1000, 6000)), REG_W'($urandom_range(200, 1000)),
                   REG_W'($urandom_range(800, 2500)), REG_W'($urandom_range(200, 1000)),
                   REG_W'($urandom_range(0, 600)));
  endtask

  // Waits until every request is taken and every result is back, then lets
  // frames that end without a result clear the pipeline.
  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_item(logic func, logic [31:0] stamp);
    in_item_t ev;
    ev.func = func;
    ev.stamp_us = stamp;
    edge_events.push_back(ev);
    queued_cnt++;
    if (func == FUNC_EDGE) begin
      gen_stamp = stamp;
      gen_have_ref = 1'b1;
    end else begin
      gen_have_ref = 1'b0;
    end
  endtask

  task automatic add_edge(logic [31:0] d);
    add_item(FUNC_EDGE, gen_stamp + d);
  endtask

  task automatic add_timeout();
    add_item(FUNC_TIMEOUT, $urandom());
  endtask

  function automatic logic [31:0] near_val(logic [REG_W-1:0] nom);
    logic [31:0] tol, lo, hi;
    tol = {16'd0, cfg_shadow[REG_TOLERANCE]};
    lo = ({16'd0, nom} > tol) ? {16'd0, nom} - tol : 32'd0;
    hi = {16'd0, nom} + tol;
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return lo + $urandom_range(0, hi - lo);
    endcase
  endfunction

  function automatic logic [31:0] miss_val(logic [REG_W-1:0] nom);
    logic [31:0] tol, lo, hi;
    tol = {16'd0, cfg_shadow[REG_TOLERANCE]};
    lo = ({16'd0, nom} > tol) ? {16'd0, nom} - tol : 32'd0;
    hi = {16'd0, nom} + tol;
    if (lo != 0 && $urandom_range(0, 1) == 0) return $urandom_range(0, lo - 1);
    return hi + 1 + $urandom_range(0, 1000);
  endfunction

  function automatic logic [31:0] short_dur();
    return $urandom_range(0, cfg_shadow[REG_GAP_THRESHOLD]);
  endfunction

  function automatic flaw_t pick_flaw();
    if ($urandom_range(0, 9) < 5) return FLAW_NONE;
    return flaw_t'($urandom_range(1, 6));
  endfunction

  task automatic start_frame();
    if (!gen_have_ref) add_edge($urandom());
  endtask

  task automatic end_frame();
    if ($urandom_range(0, 2) == 0) begin
      add_timeout();
    end else if ($urandom_range(0, 7) == 0) begin
      add_edge($urandom() | 32'h8000_0000);
    end else begin
      add_edge({16'd0, cfg_shadow[REG_GAP_THRESHOLD]} + 1 + $urandom_range(0, 3000));
    end
  endtask

  task automatic add_data_frame(logic [7:0] addr, logic [7:0] cmd, flaw_t flaw);
    logic [31:0] word;
    logic [REG_W-1:0] nom;
    int n_dur;
    int bad_at;
    int k;
    word = {addr, ~addr, cmd, ~cmd};
    if (flaw == FLAW_ADDR_SUM) word[16 + $urandom_range(0, 7)] = ~word[16 + $urandom_range(0, 7)];
    if (flaw == FLAW_CMD_SUM) word[8 + $urandom_range(0, 7)] = ~word[8 + $urandom_range(0, 7)];
    n_dur = 67;
    if (flaw == FLAW_SHORT) n_dur = $urandom_range(10, 65);
    if (flaw == FLAW_LONG) n_dur = $urandom_range(68, DURATION_SLOTS);
    if (flaw == FLAW_TAIL) n_dur = 66;
    bad_at = (flaw == FLAW_BAD_DUR) ? $urandom_range(0, 65) : -1;
    start_frame();
    for (k = 0; k < n_dur; k++) begin
      if (k == 0) nom = cfg_shadow[REG_START_PULSE];
      else if (k == 1) nom = cfg_shadow[REG_START_SPACE];
      else if (k >= DATA_DURATIONS || k % 2 == 0) nom = cfg_shadow[REG_BIT_PULSE];
      else if (word[31 - (k - 3) / 2]) nom = cfg_shadow[REG_ONE_SPACE];
      else nom = cfg_shadow[REG_ZERO_SPACE];
      add_edge((k == bad_at) ? miss_val(nom) : near_val(nom));
    end
    end_frame();
  endtask

  task automatic add_repeat_frame();
    int n;
    int k;
    n = $urandom_range(1, REPEAT_MAX);
    start_frame();
    add_edge(near_val(cfg_shadow[REG_START_PULSE]));
    for (k = 1; k < n; k++) add_edge(short_dur());
    end_frame();
  endtask

  task automatic add_noise_frame(int n);
    int k;
    start_frame();
    for (k = 0; k < n; k++) add_edge(short_dur());
    end_frame();
  endtask

  task automatic add_random_traffic(int budget);
    int stop_at;
    int pick;
    stop_at = queued_cnt + budget;
    while (queued_cnt < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) add_data_frame(8'($urandom()), 8'($urandom()), pick_flaw());
      else if (pick < 60) add_repeat_frame();
      else if (pick < 72) add_noise_frame($urandom_range(1, 80));
      else if (pick < 75) add_noise_frame($urandom_range(DURATION_SLOTS + 1, DURATION_SLOTS + 8));
      else if (pick < 88) add_timeout();
      else add_item(FUNC_EDGE, $urandom());
    end
  endtask

  initial begin
    cfg_shadow[REG_GAP_THRESHOLD] = RST_GAP_THRESHOLD;
    cfg_shadow[REG_START_PULSE] = RST_START_PULSE;
    cfg_shadow[REG_START_SPACE] = RST_START_SPACE;
    cfg_shadow[REG_BIT_PULSE] = RST_BIT_PULSE;
    cfg_shadow[REG_ONE_SPACE] = RST_ONE_SPACE;
    cfg_shadow[REG_ZERO_SPACE] = RST_ZERO_SPACE;
    cfg_shadow[REG_TOLERANCE] = RST_TOLERANCE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Timeouts on an empty frame, then a repeat code across the stamp wrap.
    add_item(FUNC_TIMEOUT, 32'h0000_0000);
    add_item(FUNC_TIMEOUT, 32'hFFFF_FFFF);
    add_item(FUNC_EDGE, 32'hFFFF_FFFF);
    add_edge(32'd9000);
    add_edge(32'd2250);
    add_edge(32'd560);
    add_edge(32'd15001);
    // A gap with nothing collected yields no result.
    add_edge(32'd20000);
    // A duration equal to the threshold still belongs to the frame.
    add_edge(32'd15000);
    repeat (9) add_edge(32'd560);
    add_timeout();
    add_item(FUNC_EDGE, 32'h0000_0000);
    add_edge(32'hFFFF_FFFF);
    add_random_traffic(PHASE_ITEMS);
    wait_drained();

    // The receiver holds off while a run of timeouts fills the block.
    program_random_timing();
    hold_req <= 1'b1;
    repeat (40) add_timeout();
    add_random_traffic(PHASE_ITEMS - 40);
    wait_drained();

    program_timing(RST_GAP_THRESHOLD, RST_START_PULSE, RST_START_SPACE, RST_BIT_PULSE,
                   RST_ONE_SPACE, RST_ZERO_SPACE, 16'd0);
    add_random_traffic(PHASE_ITEMS);
    wait_drained();

    program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_random_traffic(PHASE_ITEMS);
    wait_drained();

    program_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    add_random_traffic(PHASE_ITEMS);
    wait_drained();

    // Overlapping one and zero windows.
    program_timing(16'd20000, 16'd9000, 16'd4500, 16'd600, 16'd800, 16'd800, 16'd100);
    add_random_traffic(PHASE_ITEMS);
    wait_drained();

    program_random_timing();
    add_random_traffic(PHASE_ITEMS);
    wait_drained();

    program_timing(RST_GAP_THRESHOLD, RST_START_PULSE, RST_START_SPACE, RST_BIT_PULSE,
                   RST_ONE_SPACE, RST_ZERO_SPACE, RST_TOLERANCE);
    add_random_traffic(PHASE_ITEMS);
    wait_drained();

    fails += expected_frames.size();
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
